// File: sv/cdwa_pkg.sv
// Shared types and constants for the Collatz deficit window analyzer.
`timescale 1ns / 1ps
package cdwa_pkg;
    localparam logic [63:0] OVF_LIMIT = 64'h5555_5555_5555_5554;
    localparam int DW = 17;
    localparam int CW = 17;
    typedef struct packed {
        logic [CW-1:0] stop;
        logic [CW-1:0] after_cnt;
        logic [CW-1:0] pair_cnt;
        logic signed [DW-1:0] peak;
    } walk_res_t;
endpackage

// File: sv/cdwa_front.sv
// Front end: trajectory walk, deficit writes, danger counts.
`timescale 1ns / 1ps
module cdwa_front #(
    parameter int MAX_STEPS = 10000,
    parameter int AW = 14
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  logic [62:0] start_value,
    input  logic mem_busy,
    output logic we,
    output logic [AW-1:0] waddr,
    output logic signed [cdwa_pkg::DW-1:0] wdata,
    output logic res_valid,
    output cdwa_pkg::walk_res_t res,
    input  logic res_ready
);
    typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} st_t;
    st_t st_reg;
    logic [63:0] x_reg;
    logic [cdwa_pkg::CW-1:0] t_reg, odd_reg, ac_reg, pc_reg;
    logic [1:0] pd_reg;
    logic signed [cdwa_pkg::DW-1:0] pk_reg;
    logic [63:0] nx;
    logic danger, stop_now;
    logic signed [cdwa_pkg::DW-1:0] dnew;
    logic [cdwa_pkg::CW-1:0] oddn;

    assign nx = 64'(3 * x_reg + 64'd1);
    assign danger = nx[1:0] == 2'b10;
    assign stop_now = (t_reg == cdwa_pkg::CW'(MAX_STEPS)) ||
        (x_reg == 64'd1 && t_reg != '0) || (x_reg[0] && x_reg > cdwa_pkg::OVF_LIMIT);
    assign oddn = odd_reg + cdwa_pkg::CW'(x_reg[0]);
    assign dnew = cdwa_pkg::DW'($signed({1'b0, oddn}) * 3 -
        $signed({1'b0, t_reg + cdwa_pkg::CW'(1)}));
    assign in_ready = st_reg == S_IDLE && !mem_busy;
    assign we = (in_valid && in_ready) || (st_reg == S_WALK && !stop_now);
    assign waddr = st_reg == S_IDLE ? '0 : AW'(t_reg + cdwa_pkg::CW'(1));
    assign wdata = st_reg == S_IDLE ? '0 : dnew;
    assign res_valid = st_reg == S_DONE;
    assign res = '{stop: t_reg, after_cnt: ac_reg, pair_cnt: pc_reg, peak: pk_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
        end else begin
            case (st_reg)
                S_IDLE: if (in_valid && in_ready) begin
                    st_reg <= S_WALK;
                    x_reg <= {1'b0, start_value};
                    t_reg <= '0; odd_reg <= '0; ac_reg <= '0; pc_reg <= '0;
                    pd_reg <= 2'd0; pk_reg <= '0;
                end
                S_WALK: if (stop_now) begin
                    st_reg <= S_DONE;
                end else begin
                    t_reg <= t_reg + cdwa_pkg::CW'(1);
                    odd_reg <= oddn;
                    if (dnew > pk_reg) pk_reg <= dnew;
                    if (x_reg[0]) begin
                        x_reg <= nx;
                        if (pd_reg == 2'd2) begin
                            ac_reg <= ac_reg + cdwa_pkg::CW'(1);
                            if (danger) pc_reg <= pc_reg + cdwa_pkg::CW'(1);
                        end
                        pd_reg <= danger ? 2'd2 : 2'd1;
                    end else begin
                        x_reg <= x_reg >> 1;
                    end
                end
                S_DONE: if (res_ready) st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end
`ifndef ASSERT_OFF
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == S_DONE |-> pc_reg <= ac_reg) else $error("pair>after");
    a_t: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == S_WALK |-> t_reg <= cdwa_pkg::CW'(MAX_STEPS)) else $error("t over");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == S_DONE && !res_ready |=> st_reg == S_DONE) else $error("drop");
`endif
endmodule

// File: sv/cdwa_back.sv
// Back end: window search over the deficit memory.
`timescale 1ns / 1ps
module cdwa_back #(
    parameter int MAX_STEPS = 10000,
    parameter int AW = 14
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic we,
    input  logic [AW-1:0] waddr,
    input  logic signed [cdwa_pkg::DW-1:0] wdata,
    input  logic res_valid,
    input  cdwa_pkg::walk_res_t res,
    output logic res_ready,
    output logic mem_busy,
    output logic m_valid,
    input  logic m_ready,
    output logic [13:0] m_stop_step,
    output logic [13:0] m_window_min,
    output logic [12:0] m_peak_deficit,
    output logic m_violation,
    output logic [12:0] m_after_danger_count,
    output logic [12:0] m_danger_pair_count
);
    typedef enum logic [2:0] {S_IDLE, S_START, S_RD, S_CMP, S_OUT} st_t;
    st_t st_reg;
    logic signed [cdwa_pkg::DW-1:0] mem [0:MAX_STEPS];
    logic signed [cdwa_pkg::DW-1:0] qa_reg, qb_reg;
    logic [cdwa_pkg::CW-1:0] w_reg, k_reg;
    cdwa_pkg::walk_res_t r_reg;
    logic [AW-1:0] ra, rb;

    assign ra = AW'(k_reg);
    assign rb = AW'(k_reg + w_reg);
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        qa_reg <= mem[ra];
        qb_reg <= mem[rb];
    end
    assign res_ready = st_reg == S_IDLE;
    assign mem_busy = st_reg == S_START || st_reg == S_RD || st_reg == S_CMP;
    assign m_valid = st_reg == S_OUT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
        end else begin
            case (st_reg)
                S_IDLE: if (res_valid) begin
                    r_reg <= res; w_reg <= cdwa_pkg::CW'(1); k_reg <= '0;
                    st_reg <= S_START;
                end
                S_START: if (w_reg > r_reg.stop) begin
                    m_window_min <= 14'(r_reg.stop + cdwa_pkg::CW'(1));
                    m_violation <= 1'b1;
                    st_reg <= S_OUT;
                end else if (k_reg + w_reg > r_reg.stop) begin
                    m_window_min <= 14'(w_reg);
                    m_violation <= 1'b0;
                    st_reg <= S_OUT;
                end else begin
                    st_reg <= S_RD;
                end
                S_RD: st_reg <= S_CMP;
                S_CMP: begin
                    if (qb_reg > qa_reg) begin
                        w_reg <= w_reg + cdwa_pkg::CW'(1); k_reg <= '0;
                    end else begin
                        k_reg <= k_reg + cdwa_pkg::CW'(1);
                    end
                    st_reg <= S_START;
                end
                S_OUT: if (m_ready) st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end
    assign m_stop_step = 14'(r_reg.stop);
    assign m_peak_deficit = 13'(r_reg.peak);
    assign m_after_danger_count = 13'(r_reg.after_cnt);
    assign m_danger_pair_count = 13'(r_reg.pair_cnt);
`ifndef ASSERT_OFF
    a_w: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == S_OUT && !m_violation |-> 14'(w_reg) <= m_stop_step)
        else $error("window");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_window_min)) else $error("hold");
    a_nowr: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg != S_IDLE |-> !res_ready) else $error("ready");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_busy |-> !we) else $error("write during search");
`endif
endmodule

// File: sv/collatz_deficit_window_analyzer.sv
// Top level of the Collatz deficit window analyzer.
// Walk: the front end steps the trajectory after the accept edge; the result then waits in a one-entry handoff.
// Window search: each deficit pair passes S_START, S_RD and S_CMP; a larger later deficit
// tries the next window width from offset zero, else the offset advances.
// A new item enters only while the back end is idle or holding its result, never mid-search.
// aresetn clears control state; the deficit memory is not cleared.
`timescale 1ns / 1ps
module collatz_deficit_window_analyzer #(
    parameter int MAX_STEPS = 10000
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic [62:0] s_start_value,
    output logic m_valid,
    input  logic m_ready,
    output logic [13:0] m_stop_step,
    output logic [13:0] m_window_min,
    output logic [12:0] m_peak_deficit,
    output logic m_violation,
    output logic [12:0] m_after_danger_count,
    output logic [12:0] m_danger_pair_count
);
    localparam int AW = $clog2(MAX_STEPS + 1);
    logic we, rv, rr, busy;
    logic [AW-1:0] wa;
    logic signed [cdwa_pkg::DW-1:0] wd;
    cdwa_pkg::walk_res_t res;

    cdwa_front #(.MAX_STEPS(MAX_STEPS), .AW(AW)) u_front (
        .aclk, .aresetn, .in_valid(s_valid), .in_ready(s_ready),
        .start_value(s_start_value), .mem_busy(busy), .we, .waddr(wa), .wdata(wd),
        .res_valid(rv), .res, .res_ready(rr));
    cdwa_back #(.MAX_STEPS(MAX_STEPS), .AW(AW)) u_back (
        .aclk, .aresetn, .we, .waddr(wa), .wdata(wd), .res_valid(rv), .res,
        .res_ready(rr), .mem_busy(busy), .m_valid, .m_ready, .m_stop_step, .m_window_min,
        .m_peak_deficit, .m_violation, .m_after_danger_count, .m_danger_pair_count);
endmodule
